>>> rtl/ufc_pkg.sv
// Shared types and constants for the UART queue / flow control engine.
// No dependencies; used by ufc_queue and uart_queue_flow_control_top.
package ufc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4096;
    localparam int MAX_BURST_DEF   = 32;

    localparam logic [7:0] XON_CHAR  = 8'h11;
    localparam logic [7:0] XOFF_CHAR = 8'h13;

    // event codes (tuser)
    localparam logic [2:0] FN_RX_BYTE  = 3'd0;
    localparam logic [2:0] FN_HOST_RD  = 3'd1;
    localparam logic [2:0] FN_HOST_WR  = 3'd2;
    localparam logic [2:0] FN_TX_SLOT  = 3'd3;
    localparam logic [2:0] FN_CTS_CHG  = 3'd4;
    localparam logic [2:0] FN_FLUSH_RX = 3'd5;
    localparam logic [2:0] FN_FLUSH_TX = 3'd6;

    // flow modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_HW   = 2'd1;
    localparam logic [1:0] MODE_SW   = 2'd2;
    localparam logic [1:0] MODE_RSV  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FLOW_MODE = 2'd0;
    localparam logic [1:0] CFG_TX_BURST  = 2'd1;
    localparam logic [1:0] CFG_MARGIN    = 2'd2;

    localparam logic [5:0]  TX_BURST_RST = 6'd16;
    localparam logic [11:0] MARGIN_RST   = 12'd1024;

    localparam int IN_W  = 16;
    localparam int RES_W = 48;

    // queue command, one operation per cycle
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic [7:0] data;
    } t_qcmd;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [12:0] tx_fill;
        logic [12:0] rx_fill;
        logic        tx_enabled;
        logic        rts_level;
        logic        rx_overflow;
        logic        accepted;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } t_res;

endpackage

>>> rtl/ufc_queue.sv
// Ring queue of bytes: synchronous memory with a registered read port plus head/count.
// Depends on ufc_pkg (t_qcmd).
module ufc_queue #(
    parameter int DEPTH = ufc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ufc_pkg::t_qcmd             i_cmd,
    output logic [$clog2(DEPTH+1)-1:0] o_cnt,
    output logic [7:0]                 o_rdata
);
    import ufc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_rdata;
    logic [CW:0]   w_tail_sum;
    logic [PW-1:0] w_tail;

    // tail = head + count, wrapped by one conditional subtract
    assign w_tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_cnt);
    assign w_tail = (w_tail_sum >= (CW + 1)'(DEPTH)) ?
                    PW'(w_tail_sum - (CW + 1)'(DEPTH)) : PW'(w_tail_sum);

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (i_cmd.flush) begin
            n_head = '0;
            n_cnt  = '0;
        end else if (i_cmd.push) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.pop) begin
            n_cnt  = r_cnt - CW'(1);
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.flush) begin
            r_mem[w_tail] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop && !i_cmd.flush) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_cnt   = r_cnt;
    assign o_rdata = r_rdata;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_cnt != CW'(DEPTH)))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

endmodule

>>> rtl/uart_queue_flow_control_top.sv
// UART queue engine top: event sequencer, flow-control flags, result register.
// Depends on ufc_pkg and ufc_queue (receive and transmit ring queues).
// Results: an accepted event word is registered, then its result is loaded into the
// output register from S_EXEC; a host read loads it from S_RDAT after the queue read.
// No new event is taken before the last is done; while the output is free, a tx slot sends
// any pending XON/XOFF character, then one queued byte per cycle from the tx memory port.
// Reset (synchronous, active low) clears pointers, counts and flags at once;
// queue memories are not cleared, so there is no clearing pass.
module uart_queue_flow_control_top #(
    parameter int QUEUE_DEPTH = ufc_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_BURST   = ufc_pkg::MAX_BURST_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write port
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [11:0]               i_cfg_data,
    // event stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ufc_pkg::IN_W-1:0]  s_axis_tdata,  // [7:0] data_byte, [8] cts_level
    input  logic [2:0]                s_axis_tuser,  // [2:0] func
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte, [18] accepted,
    // [19] rx_overflow, [20] rts_level, [21] tx_enabled, [34:22] rx_fill, [47:35] tx_fill
    output logic [ufc_pkg::RES_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    import ufc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(MAX_BURST + 1);
    localparam int NW = (CW > LW) ? CW : LW;
    localparam int MW = (CW > 12) ? CW : 12;
    localparam logic [7:0]    MaxB8  = 8'(MAX_BURST);
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RDAT = 2'd2;
    localparam logic [1:0] S_TDAT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_func;
    logic [7:0]    r_byte;
    logic          r_lvl;
    logic [1:0]    r_mode;
    logic [5:0]    r_burst;
    logic [11:0]   r_margin;
    logic          r_rts, n_rts;
    logic          r_cts, n_cts;
    logic          r_peer, n_peer;
    logic          r_xon_sent, n_xon_sent;
    logic          r_pxon, n_pxon;
    logic          r_pxoff, n_pxoff;
    logic          r_active, n_active;
    logic [LW-1:0] r_left, n_left;
    logic [CW-1:0] r_tx_end, n_tx_end;
    logic          r_out_valid;
    t_res          r_out, n_res;
    logic          r_out_last, n_last;
    logic          w_load;

    t_qcmd         w_rxq_cmd, w_txq_cmd;
    logic [CW-1:0] w_rx_cnt, w_tx_cnt;
    logic [7:0]    w_rx_rdata, w_tx_rdata;

    logic [1:0]    w_mode;
    logic [CW-1:0] w_near;
    logic [LW-1:0] w_burst;
    logic          w_out_free;

    ufc_queue #(.DEPTH(QUEUE_DEPTH)) u_rxq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rxq_cmd),
        .o_cnt   (w_rx_cnt),
        .o_rdata (w_rx_rdata)
    );

    ufc_queue #(.DEPTH(QUEUE_DEPTH)) u_txq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_txq_cmd),
        .o_cnt   (w_tx_cnt),
        .o_rdata (w_tx_rdata)
    );

    assign w_mode  = (r_mode == MODE_RSV) ? MODE_NONE : r_mode;
    // near-full level, saturates at zero when the margin covers the whole queue
    assign w_near  = (MW'(r_margin) >= MW'(QUEUE_DEPTH)) ? '0 :
                     CW'(MW'(QUEUE_DEPTH) - MW'(r_margin));
    assign w_burst = ({2'b00, r_burst} > MaxB8) ? LW'(MAX_BURST) : LW'(r_burst);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        logic [CW-1:0] v_rx_new;
        logic [CW-1:0] v_tx_new;
        logic [LW-1:0] v_nsend;
        logic          v_char;
        logic [7:0]    v_char_byte;

        n_state    = r_state;
        n_rts      = r_rts;
        n_cts      = r_cts;
        n_peer     = r_peer;
        n_xon_sent = r_xon_sent;
        n_pxon     = r_pxon;
        n_pxoff    = r_pxoff;
        n_active   = r_active;
        n_left     = r_left;
        n_tx_end   = r_tx_end;
        n_res      = '0;
        n_last     = 1'b1;
        w_load     = 1'b0;
        w_rxq_cmd  = '0;
        w_txq_cmd  = '0;
        w_rxq_cmd.data = r_byte;
        w_txq_cmd.data = r_byte;
        v_rx_new    = w_rx_cnt;
        v_tx_new    = w_tx_cnt;
        v_nsend     = '0;
        v_char      = 1'b0;
        v_char_byte = XON_CHAR;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    w_load  = 1'b1;
                    case (r_func)
                        FN_RX_BYTE: begin
                            if (w_mode == MODE_SW &&
                                (r_byte == XON_CHAR || r_byte == XOFF_CHAR)) begin
                                n_peer   = (r_byte == XON_CHAR);
                                n_active = (r_byte == XON_CHAR);
                            end else begin
                                if (w_rx_cnt == DepthC) begin
                                    n_res.rx_overflow = 1'b1;
                                end else begin
                                    w_rxq_cmd.push = 1'b1;
                                    v_rx_new       = w_rx_cnt + CW'(1);
                                    n_res.accepted = 1'b1;
                                end
                                if (w_mode == MODE_HW && v_rx_new >= w_near) begin
                                    n_rts = 1'b0;
                                end
                                if (w_mode == MODE_SW && v_rx_new >= w_near && r_xon_sent) begin
                                    n_pxoff  = 1'b1;
                                    n_active = 1'b1;
                                end
                            end
                        end
                        FN_HOST_RD: begin
                            if (w_rx_cnt != '0) begin
                                w_rxq_cmd.pop = 1'b1;
                                v_rx_new      = w_rx_cnt - CW'(1);
                                if (w_mode == MODE_HW && v_rx_new < w_near && !r_rts) begin
                                    n_rts = 1'b1;
                                end
                                if (w_mode == MODE_SW && v_rx_new < w_near && !r_xon_sent) begin
                                    n_pxon   = 1'b1;
                                    n_active = 1'b1;
                                end
                                w_load  = 1'b0;
                                n_state = S_RDAT;
                            end
                        end
                        FN_HOST_WR: begin
                            if (w_tx_cnt != DepthC) begin
                                w_txq_cmd.push = 1'b1;
                                v_tx_new       = w_tx_cnt + CW'(1);
                                n_res.accepted = 1'b1;
                                if (!r_active && (w_mode == MODE_NONE ||
                                    (w_mode == MODE_HW && r_cts) ||
                                    (w_mode == MODE_SW && r_peer))) begin
                                    n_active = 1'b1;
                                end
                            end
                        end
                        FN_TX_SLOT: begin
                            if (r_active) begin
                                if (w_mode == MODE_SW && r_pxoff) begin
                                    v_char      = 1'b1;
                                    v_char_byte = XOFF_CHAR;
                                    n_pxoff     = 1'b0;
                                    n_xon_sent  = 1'b0;
                                end else if (w_mode == MODE_SW && r_pxon) begin
                                    v_char      = 1'b1;
                                    v_char_byte = XON_CHAR;
                                    n_pxon      = 1'b0;
                                    n_xon_sent  = 1'b1;
                                end
                                if (w_tx_cnt == '0 || (w_mode == MODE_SW && !r_peer)) begin
                                    n_active = 1'b0;
                                end else if (w_burst == '0) begin
                                    v_nsend = '0;
                                end else if (w_mode == MODE_HW && !r_cts) begin
                                    n_active = 1'b0;
                                end else if (NW'(w_tx_cnt) < NW'(w_burst)) begin
                                    v_nsend = LW'(w_tx_cnt);
                                end else begin
                                    v_nsend = w_burst;
                                end
                                v_tx_new = w_tx_cnt - CW'(v_nsend);
                                n_tx_end = v_tx_new;
                                if (v_nsend != '0) begin
                                    // first pop now, its byte goes out from S_TDAT
                                    w_txq_cmd.pop = 1'b1;
                                    n_left        = v_nsend - LW'(1);
                                    n_state       = S_TDAT;
                                    w_load        = v_char;
                                end
                                n_res.tx_valid = v_char;
                                n_res.tx_byte  = v_char ? v_char_byte : 8'h00;
                                n_last         = (v_nsend == '0);
                            end
                        end
                        FN_CTS_CHG: begin
                            if (w_mode == MODE_HW) begin
                                if (!r_cts && r_lvl) begin
                                    if (w_tx_cnt != '0) begin
                                        n_active = 1'b1;
                                    end
                                end else if (r_cts && !r_lvl) begin
                                    n_active = 1'b0;
                                end
                            end
                            n_cts = r_lvl;
                        end
                        FN_FLUSH_RX: begin
                            w_rxq_cmd.flush = 1'b1;
                            v_rx_new        = '0;
                            if (w_mode == MODE_HW && !r_rts) begin
                                n_rts = 1'b1;
                            end
                            if (w_mode == MODE_SW && !r_xon_sent) begin
                                n_pxon   = 1'b1;
                                n_active = 1'b1;
                            end
                        end
                        FN_FLUSH_TX: begin
                            w_txq_cmd.flush = 1'b1;
                            v_tx_new        = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_res.rts_level  = n_rts;
                    n_res.tx_enabled = n_active;
                    n_res.rx_fill    = 13'(v_rx_new);
                    n_res.tx_fill    = 13'(v_tx_new);
                end
            end
            S_RDAT: begin
                if (w_out_free) begin
                    w_load           = 1'b1;
                    n_res.read_valid = 1'b1;
                    n_res.read_byte  = w_rx_rdata;
                    n_res.rts_level  = r_rts;
                    n_res.tx_enabled = r_active;
                    n_res.rx_fill    = 13'(w_rx_cnt);
                    n_res.tx_fill    = 13'(w_tx_cnt);
                    n_state          = S_IDLE;
                end
            end
            S_TDAT: begin
                if (w_out_free) begin
                    w_load           = 1'b1;
                    n_res.tx_valid   = 1'b1;
                    n_res.tx_byte    = w_tx_rdata;
                    n_res.rts_level  = r_rts;
                    n_res.tx_enabled = r_active;
                    n_res.rx_fill    = 13'(w_rx_cnt);
                    n_res.tx_fill    = 13'(r_tx_end);
                    n_last           = (r_left == '0);
                    // next pop overlaps the output load of the current byte
                    if (r_left != '0) begin
                        w_txq_cmd.pop = 1'b1;
                        n_left        = r_left - LW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_NONE;
            r_burst    <= TX_BURST_RST;
            r_margin   <= MARGIN_RST;
            r_rts      <= 1'b1;
            r_cts      <= 1'b0;
            r_peer     <= 1'b1;
            r_xon_sent <= 1'b1;
            r_pxon     <= 1'b0;
            r_pxoff    <= 1'b0;
            r_active   <= 1'b0;
            r_left     <= '0;
            r_tx_end   <= '0;
        end else if (i_cfg_we) begin
            // the user must write these only while idle; the block does not enforce it
            unique case (i_cfg_idx)
                CFG_FLOW_MODE: begin
                    r_mode <= i_cfg_data[1:0];
                    if (i_cfg_data[1:0] == MODE_HW) begin
                        r_rts <= 1'b1;
                    end else if (i_cfg_data[1:0] == MODE_SW) begin
                        r_peer     <= 1'b1;
                        r_xon_sent <= 1'b1;
                    end
                end
                CFG_TX_BURST: r_burst  <= i_cfg_data[5:0];
                CFG_MARGIN:   r_margin <= i_cfg_data;
                default: begin
                end
            endcase
        end else begin
            r_state    <= n_state;
            r_rts      <= n_rts;
            r_cts      <= n_cts;
            r_peer     <= n_peer;
            r_xon_sent <= n_xon_sent;
            r_pxon     <= n_pxon;
            r_pxoff    <= n_pxoff;
            r_active   <= n_active;
            r_left     <= n_left;
            r_tx_end   <= n_tx_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_func <= s_axis_tuser;
            r_byte <= s_axis_tdata[7:0];
            r_lvl  <= s_axis_tdata[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out      <= n_res;
            r_out_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

    a_left_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_TDAT) |-> (r_left == '0))
        else $error("burst count left over outside burst");

    a_burst_end_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TDAT && r_left == '0) |-> (w_tx_cnt == r_tx_end))
        else $error("tx fill does not match reported end-of-burst fill");

    a_rts_mode_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mode == MODE_NONE && !i_cfg_we) |=> $stable(r_rts))
        else $error("rts moved without hardware flow control");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result register overwritten before it was taken");

endmodule

>>> bench/tb_uart_queue_flow_control_top.sv
`timescale 1ns / 100ps
// Self-checking bench for uart_queue_flow_control_top: event words in, result words out.
// Depends on ufc_pkg; carries its own behavioral copy of the queues and flow-control flags.
module tb_uart_queue_flow_control_top;
    import ufc_pkg::*;

    localparam int          DEPTH       = QUEUE_DEPTH_DEF;
    localparam int          BURST_CAP   = MAX_BURST_DEF;
    localparam logic [2:0]  FN_UNUSED   = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          WORDS_PER_PHASE = 42;

    typedef struct packed {
        logic  last;
        t_res  res;
    } uart_word_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [11:0] val;
        logic [2:0]  fn;
        logic [7:0]  data;
        logic        cts;
        logic        typed;
        t_res        res;
    } dir_row_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  burst;
        logic [11:0] margin;
        logic        quiet;
    } phase_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_idx;
    logic [11:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [RES_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;

    uart_queue_flow_control_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // behavioral engine state
    logic [7:0]  rx_mem [DEPTH];
    logic [7:0]  tx_mem [DEPTH];
    logic [11:0] rx_hd, tx_hd;
    logic [12:0] rx_cnt, tx_cnt;
    logic        rts_q, cts_q, peer_go, xon_sent, want_xon, want_xoff, tx_on;
    logic [1:0]  cfg_mode;
    logic [5:0]  cfg_burst;
    logic [11:0] cfg_margin;

    uart_word_t  uart_out_q [$];
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned burst_left;
    bit          steady_tx, steady_rx;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("uart_queue_flow_control_top regression: fail");
            $finish;
        end
    end

    // computes the result words of one event and updates the engine copy
    task automatic run_uart_engine(input logic [2:0] fn, input logic [7:0] b, input logic lvl);
        logic [1:0]  m;
        int unsigned near;
        int unsigned lim;
        logic [11:0] wr_at;
        t_res        first;
        t_res        w;
        t_res        words [$];
        m = (cfg_mode == MODE_RSV) ? MODE_NONE : cfg_mode;
        near = (cfg_margin >= DEPTH) ? 0 : DEPTH - cfg_margin;
        first = '0;
        case (fn)
            FN_RX_BYTE: begin
                if (m == MODE_SW && (b == XON_CHAR || b == XOFF_CHAR)) begin
                    peer_go = (b == XON_CHAR);
                    tx_on = peer_go;
                end else begin
                    if (rx_cnt >= DEPTH) begin
                        first.rx_overflow = 1'b1;
                    end else begin
                        wr_at = rx_hd + rx_cnt[11:0];
                        rx_mem[wr_at] = b;
                        rx_cnt++;
                        first.accepted = 1'b1;
                    end
                    if (m == MODE_HW && rx_cnt >= near) rts_q = 1'b0;
                    if (m == MODE_SW && rx_cnt >= near && xon_sent) begin
                        want_xoff = 1'b1;
                        tx_on = 1'b1;
                    end
                end
            end
            FN_HOST_RD: begin
                if (rx_cnt != 0) begin
                    first.read_valid = 1'b1;
                    first.read_byte = rx_mem[rx_hd];
                    rx_hd++;
                    rx_cnt--;
                    if (m == MODE_HW && rx_cnt < near && !rts_q) rts_q = 1'b1;
                    if (m == MODE_SW && rx_cnt < near && !xon_sent) begin
                        want_xon = 1'b1;
                        tx_on = 1'b1;
                    end
                end
            end
            FN_HOST_WR: begin
                if (tx_cnt < DEPTH) begin
                    wr_at = tx_hd + tx_cnt[11:0];
                    tx_mem[wr_at] = b;
                    tx_cnt++;
                    first.accepted = 1'b1;
                    if (!tx_on && (m == MODE_NONE || (m == MODE_HW && cts_q) ||
                                   (m == MODE_SW && peer_go)))
                        tx_on = 1'b1;
                end
            end
            FN_TX_SLOT: begin
                lim = (cfg_burst > BURST_CAP) ? BURST_CAP : cfg_burst;
                if (tx_on) begin
                    if (m == MODE_SW && (want_xoff || want_xon)) begin
                        w = '0;
                        w.tx_valid = 1'b1;
                        // XOFF wins over a pending XON
                        w.tx_byte = want_xoff ? XOFF_CHAR : XON_CHAR;
                        xon_sent = !want_xoff;
                        if (want_xoff) want_xoff = 1'b0;
                        else want_xon = 1'b0;
                        words.push_back(w);
                    end
                    if (tx_cnt == 0 || (m == MODE_SW && !peer_go)) begin
                        tx_on = 1'b0;
                    end else begin
                        for (int i = 0; i < lim && tx_cnt > 0; i++) begin
                            if (m == MODE_HW && !cts_q) begin
                                tx_on = 1'b0;
                                break;
                            end
                            w = '0;
                            w.tx_valid = 1'b1;
                            w.tx_byte = tx_mem[tx_hd];
                            tx_hd++;
                            tx_cnt--;
                            words.push_back(w);
                        end
                    end
                end
            end
            FN_CTS_CHG: begin
                if (m == MODE_HW) begin
                    if (!cts_q && lvl) begin
                        if (tx_cnt > 0) tx_on = 1'b1;
                    end else if (cts_q && !lvl) begin
                        tx_on = 1'b0;
                    end
                end
                cts_q = lvl;
            end
            FN_FLUSH_RX: begin
                rx_hd = '0;
                rx_cnt = '0;
                if (m == MODE_HW) rts_q = 1'b1;
                if (m == MODE_SW && !xon_sent) begin
                    want_xon = 1'b1;
                    tx_on = 1'b1;
                end
            end
            FN_FLUSH_TX: begin
                tx_hd = '0;
                tx_cnt = '0;
            end
            default: ;
        endcase
        if (words.size() == 0) words.push_back(first);
        foreach (words[k]) begin
            words[k].rts_level = rts_q;
            words[k].tx_enabled = tx_on;
            words[k].rx_fill = rx_cnt;
            words[k].tx_fill = tx_cnt;
            uart_out_q.push_back('{last: (k == words.size() - 1), res: words[k]});
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            CFG_FLOW_MODE: begin
                cfg_mode = val[1:0];
                if (cfg_mode == MODE_HW) begin
                    rts_q = 1'b1;
                end else if (cfg_mode == MODE_SW) begin
                    peer_go = 1'b1;
                    xon_sent = 1'b1;
                end
            end
            CFG_TX_BURST: cfg_burst = val[5:0];
            CFG_MARGIN:   cfg_margin = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_event(input logic [2:0] fn, input logic [7:0] b, input logic lvl);
        if (!steady_tx && burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, lvl, b};
        s_axis_tuser = fn;
        do @(posedge i_clk); while (!s_axis_tready);
        run_uart_engine(fn, b, lvl);
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain_results;
        s_axis_tvalid = 1'b0;
        while (uart_out_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_event(output bit counted);
        int unsigned pick;
        logic [2:0]  fn;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 26)      fn = FN_RX_BYTE;
        else if (pick < 46) fn = FN_HOST_RD;
        else if (pick < 70) fn = FN_HOST_WR;
        else if (pick < 86) fn = FN_TX_SLOT;
        else if (pick < 94) fn = FN_CTS_CHG;
        else if (pick < 97) fn = FN_FLUSH_RX;
        else if (pick < 99) fn = FN_FLUSH_TX;
        else                fn = FN_UNUSED;
        b = $urandom;
        // software flow control needs the peer's XON/XOFF often enough to matter
        if (fn == FN_RX_BYTE && cfg_mode == MODE_SW && $urandom_range(0, 3) == 0)
            b = $urandom_range(0, 1) ? XON_CHAR : XOFF_CHAR;
        send_event(fn, b, $urandom_range(0, 1));
        counted = (fn != FN_UNUSED);
    endtask

    task automatic check_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h got %0h (cycle %0d)", name, e, a, cycles);
        end
    endtask

    function automatic dir_row_t ev(input logic [2:0] fn, input logic [7:0] b, input logic c);
        dir_row_t r;
        r = '0;
        r.fn = fn;
        r.data = b;
        r.cts = c;
        return r;
    endfunction

    function automatic dir_row_t evt(input logic [2:0] fn, input logic [7:0] b, input logic acc,
                                     input logic rv, input logic [7:0] rb, input logic txen,
                                     input logic [12:0] rxf, input logic [12:0] txf);
        dir_row_t r;
        r = ev(fn, b, 1'b0);
        r.typed = 1'b1;
        r.res.accepted = acc;
        r.res.read_valid = rv;
        r.res.read_byte = rb;
        r.res.rts_level = 1'b1;
        r.res.tx_enabled = txen;
        r.res.rx_fill = rxf;
        r.res.tx_fill = txf;
        return r;
    endfunction

    function automatic dir_row_t cfg(input logic [1:0] idx, input logic [11:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    // result checker
    t_res       got;
    uart_word_t want;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (uart_out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h (cycle %0d)", m_axis_tdata, cycles);
            end else begin
                want = uart_out_q.pop_front();
                check_field("tx_valid", want.res.tx_valid, got.tx_valid);
                check_field("tx_byte", want.res.tx_byte, got.tx_byte);
                check_field("read_valid", want.res.read_valid, got.read_valid);
                check_field("read_byte", want.res.read_byte, got.read_byte);
                check_field("accepted", want.res.accepted, got.accepted);
                check_field("rx_overflow", want.res.rx_overflow, got.rx_overflow);
                check_field("rts_level", want.res.rts_level, got.rts_level);
                check_field("tx_enabled", want.res.tx_enabled, got.tx_enabled);
                check_field("rx_fill", want.res.rx_fill, got.rx_fill);
                check_field("tx_fill", want.res.tx_fill, got.tx_fill);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // receiver: ready runs with stalls in between unless steady_rx is set
    initial begin
        int run_len;
        int stall_len;
        m_axis_tready = 1'b0;
        forever begin
            run_len = $urandom_range(1, 12);
            repeat (run_len) begin
                @(negedge i_clk);
                m_axis_tready = 1'b1;
            end
            if (!steady_rx) begin
                stall_len = $urandom_range(1, 7);
                repeat (stall_len) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                end
            end
        end
    end

    initial begin
        dir_row_t   tab [$];
        phase_t     phases [$];
        uart_word_t typed_w;
        bit         counted;
        int         n;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        steady_tx = 1'b0;
        steady_rx = 1'b0;

        rx_hd = '0;
        rx_cnt = '0;
        tx_hd = '0;
        tx_cnt = '0;
        rts_q = 1'b1;
        cts_q = 1'b0;
        peer_go = 1'b1;
        xon_sent = 1'b1;
        want_xon = 1'b0;
        want_xoff = 1'b0;
        tx_on = 1'b0;
        cfg_mode = MODE_NONE;
        cfg_burst = TX_BURST_RST;
        cfg_margin = MARGIN_RST;

        // no flow control after reset: empty reads, disabled slot, extremes of data, writes, flushes
        tab.push_back(evt(FN_HOST_RD, 8'h00, 0, 0, 8'h00, 0, 13'd0, 13'd0));
        tab.push_back(evt(FN_TX_SLOT, 8'h00, 0, 0, 8'h00, 0, 13'd0, 13'd0));
        tab.push_back(evt(FN_UNUSED, 8'h00, 0, 0, 8'h00, 0, 13'd0, 13'd0));
        tab.push_back(evt(FN_RX_BYTE, 8'hFF, 1, 0, 8'h00, 0, 13'd1, 13'd0));
        tab.push_back(evt(FN_RX_BYTE, 8'h00, 1, 0, 8'h00, 0, 13'd2, 13'd0));
        tab.push_back(evt(FN_HOST_RD, 8'h00, 0, 1, 8'hFF, 0, 13'd1, 13'd0));
        tab.push_back(evt(FN_HOST_RD, 8'h00, 0, 1, 8'h00, 0, 13'd0, 13'd0));
        tab.push_back(evt(FN_RX_BYTE, XOFF_CHAR, 1, 0, 8'h00, 0, 13'd1, 13'd0));
        tab.push_back(evt(FN_HOST_WR, 8'hA5, 1, 0, 8'h00, 1, 13'd1, 13'd1));
        tab.push_back(evt(FN_HOST_WR, 8'h5A, 1, 0, 8'h00, 1, 13'd1, 13'd2));
        tab.push_back(ev(FN_TX_SLOT, 8'h00, 1'b0));
        tab.push_back(evt(FN_TX_SLOT, 8'h00, 0, 0, 8'h00, 0, 13'd1, 13'd0));
        tab.push_back(evt(FN_CTS_CHG, 8'h00, 0, 0, 8'h00, 0, 13'd1, 13'd0));
        tab[$].cts = 1'b1;
        tab.push_back(ev(FN_HOST_WR, 8'hFF, 1'b0));
        tab.push_back(evt(FN_FLUSH_TX, 8'h00, 0, 0, 8'h00, 1, 13'd1, 13'd0));
        tab.push_back(evt(FN_FLUSH_RX, 8'h00, 0, 0, 8'h00, 1, 13'd0, 13'd0));
        tab.push_back(evt(FN_TX_SLOT, 8'h00, 0, 0, 8'h00, 0, 13'd0, 13'd0));
        // software flow control: peer XOFF is consumed and stops the transmitter
        tab.push_back(cfg(CFG_FLOW_MODE, {10'd0, MODE_SW}));
        tab.push_back(evt(FN_RX_BYTE, XOFF_CHAR, 0, 0, 8'h00, 0, 13'd0, 13'd0));
        tab.push_back(ev(FN_HOST_WR, 8'h3C, 1'b0));
        tab.push_back(ev(FN_RX_BYTE, XON_CHAR, 1'b0));
        // zero burst sends no data, oversized burst is clamped
        tab.push_back(cfg(CFG_TX_BURST, 12'd0));
        tab.push_back(ev(FN_TX_SLOT, 8'h00, 1'b0));
        tab.push_back(cfg(CFG_TX_BURST, 12'd63));
        tab.push_back(ev(FN_HOST_WR, 8'hC3, 1'b0));
        tab.push_back(ev(FN_TX_SLOT, 8'h00, 1'b0));
        // reserved mode acts as no flow control
        tab.push_back(cfg(CFG_FLOW_MODE, {10'd0, MODE_RSV}));
        tab.push_back(ev(FN_CTS_CHG, 8'h00, 1'b0));
        tab.push_back(ev(FN_RX_BYTE, XON_CHAR, 1'b1));

        phases.push_back('{MODE_HW,   6'd1,  12'd4095, 1'b0});
        phases.push_back('{MODE_SW,   6'd32, 12'd4093, 1'b0});
        phases.push_back('{MODE_NONE, 6'd5,  12'd1,    1'b1});
        phases.push_back('{MODE_SW,   6'd0,  12'd4095, 1'b0});
        phases.push_back('{MODE_HW,   6'd63, 12'd4090, 1'b1});
        phases.push_back('{MODE_SW,   6'd3,  12'd4094, 1'b0});
        phases.push_back('{MODE_RSV,  6'd16, 12'd2048, 1'b0});

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (tab[r]) begin
            if (tab[r].is_cfg) begin
                drain_results();
                write_reg(tab[r].idx, tab[r].val);
            end else begin
                send_event(tab[r].fn, tab[r].data, tab[r].cts);
                if (tab[r].typed) begin
                    typed_w.last = 1'b1;
                    typed_w.res = tab[r].res;
                    uart_out_q[uart_out_q.size() - 1] = typed_w;
                end
            end
        end

        foreach (phases[p]) begin
            drain_results();
            write_reg(CFG_FLOW_MODE, {10'd0, phases[p].mode});
            write_reg(CFG_TX_BURST, {6'd0, phases[p].burst});
            write_reg(CFG_MARGIN, phases[p].margin);
            steady_tx = phases[p].quiet;
            steady_rx = phases[p].quiet;
            n = 0;
            while (n < WORDS_PER_PHASE) begin
                random_event(counted);
                if (counted) n++;
            end
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && uart_out_q.size() == 0)
            $display("uart_queue_flow_control_top regression: pass");
        else
            $display("uart_queue_flow_control_top regression: fail");
        $finish;
    end

endmodule
